### rtl/core/aabb_pkg.sv
// Package for the AABB broad-phase collision block: item types, codes, constants.
// Used by all modules under rtl/core and by the checker.
`default_nettype none
package aabb_pkg;
  localparam int unsigned MaxObjects = 16;
  localparam int unsigned FracBits = 16;
  localparam int unsigned SlotW = $clog2(MaxObjects);

  localparam logic [1:0] FuncClass = 2'd0;
  localparam logic [1:0] FuncCoef = 2'd1;
  localparam logic [1:0] FuncVertex = 2'd2;
  localparam logic [1:0] FuncMove = 2'd3;

  localparam logic [1:0] ClassNone = 2'd0;
  localparam logic [1:0] ClassStatic = 2'd1;
  localparam logic [1:0] ClassMovable = 2'd2;

  localparam logic signed [31:0] PosMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] NegMax = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0] func;
    logic [3:0] object_id;
    logic [1:0] object_class;
    logic [2:0] coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
    logic first_vertex;
  } in_item_t;

  typedef struct packed {
    logic moved_is_movable;
    logic collided;
    logic [3:0] hit_movable_id;
    logic [3:0] hit_static_id;
    logic signed [31:0] static_top_y;
    logic [30:0] penetration_gap;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture the input item
    logic mul_step;    // run one transform term
    logic acc_clr;
    logic fold;        // fold transformed vertex into bounds
    logic scan_clr;    // restart pair scan
    logic scan_step;   // compare one pair
    logic emit;        // drive result
  } aabb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic hit;
    logic mul_last;
  } aabb_sts_t;
endpackage
`default_nettype wire

### rtl/core/aabb_ctrl.sv
// Controller state machine for the AABB block.
// Depends on aabb_pkg.
`default_nettype none
module aabb_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic [1:0] func,
  input  wire aabb_pkg::aabb_sts_t sts,
  output logic busy,
  output aabb_pkg::aabb_cmd_t cmd
);
  typedef enum logic [2:0] {S_IDLE, S_MUL, S_FOLD, S_SCAN, S_EMIT} state_t;
  state_t state_r, state_nxt;
  logic busy_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          cmd.acc_clr = 1'b1;
          cmd.scan_clr = 1'b1;
          if (func == aabb_pkg::FuncVertex) state_nxt = S_MUL;
          else if (func == aabb_pkg::FuncMove) state_nxt = S_SCAN;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_last) state_nxt = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (sts.hit || sts.scan_done) state_nxt = S_EMIT;
        else cmd.scan_step = 1'b1;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    busy_nxt = (state_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy <= busy_nxt;
    end
  end
endmodule
`default_nettype wire

### rtl/core/aabb_dp.sv
// Datapath for the AABB block: class table, matrix, bounds, transform and pair scan.
// Depends on aabb_pkg.
`default_nettype none
module aabb_dp (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire aabb_pkg::in_item_t in_item,
  input  wire aabb_pkg::aabb_cmd_t cmd,
  output aabb_pkg::aabb_sts_t sts,
  output logic out_valid,
  output aabb_pkg::out_item_t out_item
);
  localparam int unsigned N = aabb_pkg::MaxObjects;
  localparam int unsigned SW = aabb_pkg::SlotW;

  logic [1:0] cls_r [N];
  logic signed [31:0] mat_r [8];
  logic signed [31:0] minx_r [N], miny_r [N], maxx_r [N], maxy_r [N];
  aabb_pkg::in_item_t it_r;
  logic in_range_r;
  logic [SW-1:0] slot_r;

  // transform: 8 steps, term index k (row = k[2], col = k[1:0])
  // each scaled product needs 48 bits; three of them plus an offset fit in 50
  logic [2:0] k_r;
  logic signed [49:0] accx_r, accy_r;
  logic signed [31:0] vsel, msel;
  logic signed [63:0] prod;
  logic signed [49:0] term;
  logic signed [31:0] wx, wy;

  always_comb begin
    case (k_r[1:0])
      2'd0: vsel = it_r.vertex_x;
      2'd1: vsel = it_r.vertex_y;
      default: vsel = it_r.vertex_z;
    endcase
    msel = mat_r[k_r];
    prod = 64'(msel) * 64'(vsel);
    if (k_r[1:0] == 2'd3) term = 50'(msel);
    else term = 50'(prod >>> aabb_pkg::FracBits);
  end

  function automatic logic signed [31:0] sat(input logic signed [49:0] v);
    if (v > 50'(aabb_pkg::PosMax)) return aabb_pkg::PosMax;
    if (v < 50'(aabb_pkg::NegMax)) return aabb_pkg::NegMax;
    return v[31:0];
  endfunction

  assign wx = sat(accx_r);
  assign wy = sat(accy_r);
  assign sts.mul_last = (k_r == 3'd7);

  // pair scan
  logic [SW-1:0] m_r, t_r;
  logic mwrap_r;
  logic hit_r;
  logic overlap;
  assign overlap = (cls_r[m_r] == aabb_pkg::ClassMovable) &&
                   (cls_r[t_r] == aabb_pkg::ClassStatic) &&
                   (minx_r[m_r] <= maxx_r[t_r]) && (maxx_r[m_r] >= minx_r[t_r]) &&
                   (miny_r[m_r] <= maxy_r[t_r]) && (maxy_r[m_r] >= miny_r[t_r]);
  logic movable;
  assign movable = in_range_r && (cls_r[slot_r] == aabb_pkg::ClassMovable);
  assign sts.hit = hit_r;
  assign sts.scan_done = mwrap_r || !movable;

  logic signed [32:0] gap;
  logic [32:0] agap;
  always_comb begin
    gap = 33'(miny_r[m_r]) - 33'(maxy_r[t_r]);
    agap = gap[32] ? 33'(-gap) : 33'(gap);
  end

  aabb_pkg::out_item_t out_nxt;
  always_comb begin
    out_nxt = '0;
    out_nxt.moved_is_movable = movable;
    if (movable && hit_r) begin
      out_nxt.collided = 1'b1;
      out_nxt.hit_movable_id = 4'(m_r);
      out_nxt.hit_static_id = 4'(t_r);
      out_nxt.static_top_y = maxy_r[t_r];
      out_nxt.penetration_gap = agap[32:31] != 2'b00 ? 31'h7FFF_FFFF : agap[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) begin
        cls_r[i] <= aabb_pkg::ClassNone;
        minx_r[i] <= aabb_pkg::PosMax;
        miny_r[i] <= aabb_pkg::PosMax;
        maxx_r[i] <= aabb_pkg::NegMax;
        maxy_r[i] <= aabb_pkg::NegMax;
      end
      for (int j = 0; j < 8; j++) mat_r[j] <= '0;
      out_valid <= 1'b0;
      hit_r <= 1'b0;
      mwrap_r <= 1'b0;
      k_r <= '0;
    end else begin
      out_valid <= 1'b0;
      if (cmd.load) begin
        it_r <= in_item;
        in_range_r <= ({28'd0, in_item.object_id} < 32'(N));
        slot_r <= SW'(in_item.object_id);
        if (in_item.func == aabb_pkg::FuncClass && {28'd0, in_item.object_id} < 32'(N))
          cls_r[SW'(in_item.object_id)] <= (in_item.object_class == 2'd3) ?
                                            aabb_pkg::ClassNone : in_item.object_class;
        if (in_item.func == aabb_pkg::FuncCoef)
          mat_r[in_item.coef_index] <= in_item.coef_value;
      end
      if (cmd.acc_clr) begin
        accx_r <= '0;
        accy_r <= '0;
        k_r <= '0;
      end
      if (cmd.mul_step) begin
        if (k_r[2]) accy_r <= accy_r + term;
        else accx_r <= accx_r + term;
        k_r <= k_r + 3'd1;
      end
      if (cmd.fold && in_range_r) begin
        if (it_r.first_vertex) begin
          minx_r[slot_r] <= wx;
          miny_r[slot_r] <= wy;
          maxx_r[slot_r] <= wx;
          maxy_r[slot_r] <= wy;
        end else begin
          if (wx < minx_r[slot_r]) minx_r[slot_r] <= wx;
          if (wy < miny_r[slot_r]) miny_r[slot_r] <= wy;
          if (wx > maxx_r[slot_r]) maxx_r[slot_r] <= wx;
          if (wy > maxy_r[slot_r]) maxy_r[slot_r] <= wy;
        end
      end
      if (cmd.scan_clr) begin
        m_r <= '0;
        t_r <= '0;
        mwrap_r <= 1'b0;
        hit_r <= 1'b0;
      end
      if (cmd.scan_step) begin
        if (overlap) hit_r <= 1'b1;
        else begin
          t_r <= t_r + 1'b1;
          if (t_r == SW'(N - 1)) begin
            m_r <= m_r + 1'b1;
            if (m_r == SW'(N - 1)) mwrap_r <= 1'b1;
          end
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        out_item <= out_nxt;
      end
    end
  end
endmodule
`default_nettype wire

### rtl/core/aabb_broad_phase_collision_top.sv
// Top level of the AABB broad-phase collision block.
// Depends on aabb_pkg, aabb_ctrl and aabb_dp.
//
// Class and coefficient items are captured at start without leaving the idle
// state; a vertex runs eight multiply-accumulate steps on one shared 32x32
// multiplier, then a fold into the slot's bounds. A movement notice scans slot
// pairs one per cycle, up to MaxObjects squared (256) pairs, stopping at the
// first overlap; the result strobes out_valid for one cycle and cannot be stalled.
`default_nettype none
module aabb_broad_phase_collision_top (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic busy,
  input  wire aabb_pkg::in_item_t in_item,
  output logic out_valid,
  output aabb_pkg::out_item_t out_item
);
  aabb_pkg::aabb_cmd_t cmd;
  aabb_pkg::aabb_sts_t sts;

  aabb_ctrl u_ctrl (.clk, .rst_n, .start, .func(in_item.func), .sts, .busy, .cmd);
  aabb_dp u_dp (.clk, .rst_n, .in_item, .cmd, .sts, .out_valid, .out_item);
endmodule
`default_nettype wire

### rtl/core/aabb_chk.sv
// Port-level checker for the AABB block, bound to the top level.
// Depends on aabb_pkg.
`default_nettype none
module aabb_chk (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire aabb_pkg::in_item_t in_item,
  input wire logic out_valid,
  input wire aabb_pkg::out_item_t out_item
);
  a_busy_after_move: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.func == aabb_pkg::FuncMove |=> busy) else $error("no busy");
  a_no_hit_unless_movable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.moved_is_movable |-> !out_item.collided) else $error("bad hit");
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double strobe");
  a_idle_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("busy at result");
endmodule

bind aabb_broad_phase_collision_top aabb_chk u_chk (.*);
`default_nettype wire
